/* design/kbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared types, register indexes and helpers of the knob/button dimmer control.
// ----------------------------------------------------------------------------
package kbd_pkg;

    localparam int NUM_CH     = 4;
    localparam int MAIN_CH    = 3;
    localparam int GREEN_CH   = 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_STEP    = 3'd4;

    localparam logic [15:0] RST_LONG_PRESS  = 16'd1000;
    localparam logic [15:0] RST_DEBOUNCE    = 16'd50;
    localparam logic [6:0]  RST_KNOB_THRESH = 7'd2;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic {
        KIND_TICK,
        KIND_LOAD
    } t_kind;

    typedef enum logic [1:0] {
        LIGHT_OFF,
        LIGHT_MAIN,
        LIGHT_ADD
    } t_light;

    typedef struct packed {
        logic              command;
        logic [15:0]       elapsed_ms;
        logic              button_level;
        logic signed [7:0] knob_delta;
        logic [7:0]        load_level_0;
        logic [7:0]        load_level_1;
        logic [7:0]        load_level_2;
        logic [7:0]        load_level_3;
    } t_dim_in;

    typedef struct packed {
        logic [7:0] out_level_0;
        logic [7:0] out_level_1;
        logic [7:0] out_level_2;
        logic [7:0] out_level_3;
        logic [7:0] fade_step;
        logic       save_request;
        logic       last;
    } t_dim_out;

    // Classified item handed from the front end to the executor
    typedef struct packed {
        t_kind   kind;
        t_dim_in item;
    } t_work;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    typedef logic [NUM_CH-1:0][7:0] t_levels;

    function automatic t_light f_light(input t_levels lv);
        t_light st;
        if (lv[MAIN_CH] != 8'd0) begin
            st = LIGHT_MAIN;
        end else if (lv[0] != 8'd0 || lv[1] != 8'd0 || lv[2] != 8'd0) begin
            st = LIGHT_ADD;
        end else begin
            st = LIGHT_OFF;
        end
        return st;
    endfunction

    function automatic t_dim_out f_result(input t_levels lv, input logic [7:0] fade,
                                          input logic save);
        t_dim_out r;
        r.out_level_0  = lv[0];
        r.out_level_1  = lv[1];
        r.out_level_2  = lv[2];
        r.out_level_3  = lv[3];
        r.fade_step    = fade;
        r.save_request = save;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

/* design/kbd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_front
// Input side: takes items, tags them as tick or load, buffers two of them.
// ----------------------------------------------------------------------------
module kbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  kbd_pkg::t_dim_in i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output kbd_pkg::t_work  o_work
);

    kbd_pkg::t_work r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;
    logic           w_in_xfer;
    logic           w_out_xfer;
    kbd_pkg::t_work w_work;

    assign full       = (r_count == 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_work     = r_mem[r_rd_ptr];
    assign w_in_xfer  = push && !full;
    assign w_out_xfer = o_valid && i_ready;

    always_comb begin
        w_work.item = i_item;
        w_work.kind = (i_item.command == kbd_pkg::CMD_LOAD) ? kbd_pkg::KIND_LOAD
                                                            : kbd_pkg::KIND_TICK;
    end

    always_comb begin
        n_wr_ptr = w_in_xfer  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_out_xfer ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_in_xfer} - {1'b0, w_out_xfer};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mem[r_wr_ptr] <= w_work;
        end
    end

endmodule

/* design/kbd_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_exec
// Back end: holds settings and light state, runs one item per cycle while the
// result queue has room and hands zero to three results to the result queue.
// ----------------------------------------------------------------------------
module kbd_exec (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kbd_pkg::t_cfg_wr         i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  kbd_pkg::t_work           i_work,
    input  logic                     i_room,
    output logic [1:0]               o_wr_n,
    output kbd_pkg::t_dim_out [2:0]  o_wr_data
);

    logic [15:0]       r_long_press;
    logic [15:0]       r_debounce;
    logic [6:0]        r_knob_thresh;
    logic [7:0]        r_on_step;
    logic [7:0]        r_off_step;

    kbd_pkg::t_levels  r_levels;
    logic [7:0]        r_main_def;
    logic [7:0]        r_green_def;
    logic              r_held;
    logic [16:0]       r_press;
    logic signed [8:0] r_acc;

    kbd_pkg::t_levels  n_levels;
    logic [7:0]        n_main_def;
    logic [7:0]        n_green_def;
    logic              n_held;
    logic [16:0]       n_press;
    logic signed [8:0] n_acc;

    logic              w_xfer;

    assign o_ready = i_room;
    assign w_xfer  = i_valid && i_room;

    always_comb begin
        kbd_pkg::t_levels          lv;
        kbd_pkg::t_dim_out [2:0]   res;
        logic [1:0]                n;
        logic signed [9:0]         acc10;
        logic signed [8:0]         acc;
        logic [17:0]               pt18;
        logic [16:0]               pt;
        logic [16:0]               long17;
        logic                      held;
        kbd_pkg::t_light           st;
        logic signed [8:0]         thr_s;
        logic signed [8:0]         c;
        logic signed [9:0]         v;
        logic [1:0]                ch;

        lv     = r_levels;
        res    = '0;
        n      = 2'd0;
        acc    = r_acc;
        pt     = r_press;
        held   = r_held;
        long17 = {1'b0, r_long_press};
        thr_s  = signed'({2'b00, r_knob_thresh});
        acc10  = '0;
        pt18   = '0;
        st     = kbd_pkg::LIGHT_OFF;
        c      = '0;
        v      = '0;
        ch     = 2'(kbd_pkg::MAIN_CH);
        n_main_def  = r_main_def;
        n_green_def = r_green_def;

        if (w_xfer) begin
            if (i_work.kind == kbd_pkg::KIND_LOAD) begin
                lv[0] = i_work.item.load_level_0;
                lv[1] = i_work.item.load_level_1;
                lv[2] = i_work.item.load_level_2;
                lv[3] = i_work.item.load_level_3;
            end else begin
                // knob accumulator, saturating at -256..255
                acc10 = {r_acc[8], r_acc} + 10'(i_work.item.knob_delta);
                if (acc10 > 10'sd255) begin
                    acc = 9'sd255;
                end else if (acc10 < -10'sd256) begin
                    acc = -9'sd256;
                end else begin
                    acc = acc10[8:0];
                end

                // long press fires once when the held time crosses the limit
                if (held && pt < long17) begin
                    pt18 = {1'b0, pt} + {2'b00, i_work.item.elapsed_ms};
                    pt   = pt18[17] ? 17'h1FFFF : pt18[16:0];
                    if (pt >= long17) begin
                        st = kbd_pkg::f_light(lv);
                        if (st == kbd_pkg::LIGHT_OFF) begin
                            lv[kbd_pkg::GREEN_CH] = n_green_def;
                            res[n] = kbd_pkg::f_result(lv, r_on_step, 1'b1);
                            n = n + 2'd1;
                        end else begin
                            if (st == kbd_pkg::LIGHT_MAIN) begin
                                n_main_def = lv[kbd_pkg::MAIN_CH];
                            end else begin
                                n_green_def = lv[kbd_pkg::GREEN_CH];
                            end
                            for (int i = 0; i < kbd_pkg::NUM_CH; i++) begin
                                lv[i] = lv[i] >> 1;
                            end
                            res[n] = kbd_pkg::f_result(lv, 8'd0, 1'b1);
                            n = n + 2'd1;
                            lv = '0;
                            res[n] = kbd_pkg::f_result(lv, r_off_step, 1'b1);
                            n = n + 2'd1;
                        end
                    end
                end

                // button edge: press restarts the timer, release may be a short press
                if (i_work.item.button_level != held) begin
                    if (i_work.item.button_level) begin
                        pt = '0;
                    end else if (pt > {1'b0, r_debounce} && pt < long17) begin
                        st = kbd_pkg::f_light(lv);
                        if (st == kbd_pkg::LIGHT_OFF) begin
                            lv[kbd_pkg::MAIN_CH] = n_main_def;
                            res[n] = kbd_pkg::f_result(lv, r_on_step, 1'b0);
                            n = n + 2'd1;
                        end else begin
                            for (int i = 0; i < kbd_pkg::NUM_CH; i++) begin
                                lv[i] = lv[i] >> 1;
                            end
                            res[n] = kbd_pkg::f_result(lv, 8'd0, 1'b0);
                            n = n + 2'd1;
                            lv = '0;
                            res[n] = kbd_pkg::f_result(lv, r_off_step, 1'b0);
                            n = n + 2'd1;
                        end
                    end
                    held = i_work.item.button_level;
                end

                // knob: while off the count must reach the threshold
                st = kbd_pkg::f_light(lv);
                if (acc != 9'sd0 && (st != kbd_pkg::LIGHT_OFF || acc <= -thr_s
                                     || acc >= thr_s)) begin
                    if (acc < -9'sd128) begin
                        c = -9'sd128;
                    end else if (acc > 9'sd128) begin
                        c = 9'sd128;
                    end else begin
                        c = acc;
                    end
                    if (st == kbd_pkg::LIGHT_OFF) begin
                        if (c > 9'sd0) begin
                            lv[kbd_pkg::MAIN_CH] = c[7:0];
                            res[n] = kbd_pkg::f_result(lv, 8'd0, 1'b0);
                            n = n + 2'd1;
                        end
                    end else begin
                        ch = (st == kbd_pkg::LIGHT_MAIN) ? 2'(kbd_pkg::MAIN_CH)
                                                         : 2'(kbd_pkg::GREEN_CH);
                        v = signed'({2'b00, lv[ch]}) + {c[8], c};
                        if (v > 10'sd255) begin
                            lv[ch] = 8'd255;
                        end else if (v < 10'sd0) begin
                            lv[ch] = 8'd0;
                        end else begin
                            lv[ch] = v[7:0];
                        end
                        res[n] = kbd_pkg::f_result(lv, 8'd0, 1'b0);
                        n = n + 2'd1;
                    end
                    acc = '0;
                end

                if (n != 2'd0) begin
                    res[n - 2'd1].last = 1'b1;
                end
            end
        end

        n_levels  = lv;
        n_held    = held;
        n_press   = pt;
        n_acc     = acc;
        o_wr_n    = n;
        o_wr_data = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press  <= kbd_pkg::RST_LONG_PRESS;
            r_debounce    <= kbd_pkg::RST_DEBOUNCE;
            r_knob_thresh <= kbd_pkg::RST_KNOB_THRESH;
            r_on_step     <= 8'd0;
            r_off_step    <= 8'd0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                kbd_pkg::CFG_LONG_PRESS:  r_long_press  <= i_cfg.wdata;
                kbd_pkg::CFG_DEBOUNCE:    r_debounce    <= i_cfg.wdata;
                kbd_pkg::CFG_KNOB_THRESH: r_knob_thresh <= i_cfg.wdata[6:0];
                kbd_pkg::CFG_ON_STEP:     r_on_step     <= i_cfg.wdata[7:0];
                kbd_pkg::CFG_OFF_STEP:    r_off_step    <= i_cfg.wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= '0;
            r_main_def  <= 8'd0;
            r_green_def <= 8'd0;
            r_held      <= 1'b0;
            r_press     <= '0;
            r_acc       <= '0;
        end else begin
            r_levels    <= n_levels;
            r_main_def  <= n_main_def;
            r_green_def <= n_green_def;
            r_held      <= n_held;
            r_press     <= n_press;
            r_acc       <= n_acc;
        end
    end

endmodule

/* design/kbd_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_outq
// Result queue: four entries, takes up to three results per cycle, pops one.
// ----------------------------------------------------------------------------
module kbd_outq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [1:0]               i_wr_n,
    input  kbd_pkg::t_dim_out [2:0]  i_wr_data,
    output logic                     o_room,
    output logic                     empty,
    input  logic                     pop,
    output kbd_pkg::t_dim_out        o_result
);

    kbd_pkg::t_dim_out r_mem [4];
    logic [1:0]        r_wr_ptr;
    logic [1:0]        r_rd_ptr;
    logic [2:0]        r_count;
    logic [1:0]        n_wr_ptr;
    logic [1:0]        n_rd_ptr;
    logic [2:0]        n_count;
    logic              w_pop_xfer;

    // room for a worst-case burst of three results
    assign o_room     = (r_count <= 3'd1);
    assign empty      = (r_count == 3'd0);
    assign o_result   = r_mem[r_rd_ptr];
    assign w_pop_xfer = pop && !empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_wr_n;
        n_rd_ptr = r_rd_ptr + {1'b0, w_pop_xfer};
        n_count  = r_count + {1'b0, i_wr_n} - {2'b00, w_pop_xfer};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_wr_n) begin
                r_mem[r_wr_ptr + 2'(k)] <= i_wr_data[k];
            end
        end
    end

endmodule

/* design/knob_button_dimmer_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_button_dimmer_control
// Four-channel dimmer control from a knob and a push button: ticks drive
// press timing and knob counts, loads overwrite levels; each level change
// made by a tick comes out as one result, a load gives none.
//
//  channel   | ports                             | transfer when
//  ----------+-----------------------------------+-----------------------
//  items in  | push, full, i_item                | push && !full
//  results   | empty, pop, o_result              | pop && !empty
//  settings  | i_cfg_we, i_cfg_idx, i_cfg_wdata  | i_cfg_we
//
// An item is registered in the two-entry input buffer and executed from its
// head when the result queue has room; its 0..3 results enter the result queue
// at that edge and leave it through o_result. One item per cycle is
// sustained while each item yields at most one result and results are popped
// every cycle; the executor waits when the four-entry result queue holds more
// than one result. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
module knob_button_dimmer_control (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  kbd_pkg::t_dim_in                   i_item,
    output logic                               empty,
    input  logic                               pop,
    output kbd_pkg::t_dim_out                  o_result,
    input  logic                               i_cfg_we,
    input  logic [kbd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kbd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    kbd_pkg::t_cfg_wr             w_cfg;
    kbd_pkg::t_work               w_work;
    logic                         w_work_valid;
    logic                         w_work_ready;
    logic                         w_room;
    logic [1:0]                   w_wr_n;
    kbd_pkg::t_dim_out [2:0]      w_wr_data;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.idx   = i_cfg_idx;
    assign w_cfg.wdata = i_cfg_wdata;

    kbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_valid (w_work_valid),
        .i_ready (w_work_ready),
        .o_work  (w_work)
    );

    kbd_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_work_valid),
        .o_ready   (w_work_ready),
        .i_work    (w_work),
        .i_room    (w_room),
        .o_wr_n    (w_wr_n),
        .o_wr_data (w_wr_data)
    );

    kbd_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_n    (w_wr_n),
        .i_wr_data (w_wr_data),
        .o_room    (w_room),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule
